// ===== rtl/bcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types and default sizes for the blank column segmenter.
// ----------------------------------------------------------------------------
package bcs_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int MAX_COLUMNS_DEF      = 4096;
    localparam int MAX_SEGMENTS_DEF     = 256;
    localparam int MERGE_COUNT_BITS_DEF = 4;

    // Fixed field widths of the channels.
    localparam int REQ_W      = 2;
    localparam int CHAN_W     = 8;
    localparam int PIXEL_W    = 4 * CHAN_W;
    localparam int MERGE_IDX_W = 8;
    localparam int OUT_SEG_W  = 8;
    localparam int OUT_COL_W  = 12;

    // Request codes carried on the input channel.
    typedef enum logic [REQ_W-1:0] {
        REQ_PIXEL = 2'd0,
        REQ_MERGE = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

endpackage

// ===== rtl/bcs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bcs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/blank_column_segmenter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blank_column_segmenter_top
// Column projection segmentation of a column-major pixel stream.
// ----------------------------------------------------------------------------
// Requests enter on a valid/ready channel: pixels (with an end-of-column
// mark), merge entries and new-image clears. Each segment found is offered
// on a valid/ready result channel as number, first column, exclusive end
// column and a merged flag. A pixel that closes a run produces at most one
// result; all other requests produce none.
// Throughput is one request per cycle while the result channel is not
// stalled. A request is registered on acceptance in the processing stage
// input register, processed there together with the registered read of
// the merge-count RAM, and its result is then registered in the output
// register that drives o_valid. The RAM read address of a new pixel or
// clear request is taken from the segment count that the request ahead
// leaves, and a write by that request to the same entry is forwarded.
// Reset, and a clear request, empty the merge table at once through one
// valid bit per entry, so there is no clearing pass. The background colour
// register is written through i_cfg_wr_en / i_cfg_wr_data and survives a
// clear request. When the receiver stalls with a result waiting, the
// processing stage holds and o_ready drops once that stage is also full.
// ----------------------------------------------------------------------------
module blank_column_segmenter_top #(
    parameter int MAX_COLUMNS      = bcs_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_SEGMENTS     = bcs_pkg::MAX_SEGMENTS_DEF,
    parameter int MERGE_COUNT_BITS = bcs_pkg::MERGE_COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_wr_en,
    input  logic [bcs_pkg::PIXEL_W-1:0]     i_cfg_wr_data,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bcs_pkg::REQ_W-1:0]       i_req_type,
    input  logic [bcs_pkg::CHAN_W-1:0]      i_red,
    input  logic [bcs_pkg::CHAN_W-1:0]      i_green,
    input  logic [bcs_pkg::CHAN_W-1:0]      i_blue,
    input  logic [bcs_pkg::CHAN_W-1:0]      i_alpha,
    input  logic                            i_column_end,
    input  logic [bcs_pkg::MERGE_IDX_W-1:0] i_merge_index,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bcs_pkg::OUT_SEG_W-1:0]   o_segment_index,
    output logic [bcs_pkg::OUT_COL_W-1:0]   o_start_column,
    output logic [bcs_pkg::OUT_COL_W-1:0]   o_end_column,
    output logic                            o_was_merged
);

    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int SEG_IDX_W   = $clog2(MAX_SEGMENTS);
    localparam int SEG_CNT_W   = $clog2(MAX_SEGMENTS + 1);
    localparam int TABLE_DEPTH = 1 << SEG_IDX_W;
    localparam int CNT_W       = MERGE_COUNT_BITS;

    // Configuration.
    logic [bcs_pkg::PIXEL_W-1:0]     r_bg_color;

    // Processing stage input register.
    logic                            r_a_valid;
    bcs_pkg::t_req                   r_a_req;
    logic [bcs_pkg::PIXEL_W-1:0]     r_a_pixel;
    logic                            r_a_col_end;
    logic [bcs_pkg::MERGE_IDX_W-1:0] r_a_mi;
    logic                            r_a_vbit;
    logic                            r_a_fwd_hit;
    logic [CNT_W-1:0]                r_a_fwd_data;

    // Segmentation state.
    logic [COL_W-1:0]                r_col_num,    n_col_num;
    logic                            r_col_blank,  n_col_blank;
    logic                            r_run_open,   n_run_open;
    logic [COL_W-1:0]                r_run_start,  n_run_start;
    logic                            r_merge_act,  n_merge_act;
    logic [COL_W-1:0]                r_merge_start, n_merge_start;
    logic [SEG_CNT_W-1:0]            r_seg_count,  n_seg_count;
    logic [TABLE_DEPTH-1:0]          r_tbl_valid;

    // Output register.
    logic                            r_out_valid;
    logic [bcs_pkg::OUT_SEG_W-1:0]   r_out_seg;
    logic [bcs_pkg::OUT_COL_W-1:0]   r_out_start;
    logic [bcs_pkg::OUT_COL_W-1:0]   r_out_end;
    logic                            r_out_merged;

    // Stage control and table access.
    logic                            a_advance;
    logic                            a_fire;
    logic                            in_accept;
    logic [CNT_W-1:0]                ram_rd_data;
    logic [CNT_W-1:0]                cnt_eff;
    logic [SEG_IDX_W-1:0]            rd_addr;
    logic                            wr_en;
    logic [SEG_IDX_W-1:0]            wr_addr;
    logic [CNT_W-1:0]                wr_data;
    logic                            tbl_clear;
    logic                            emit;
    logic [COL_W-1:0]                emit_first;
    logic                            emit_merged;

    assign a_advance = !r_out_valid || i_ready;
    assign a_fire    = r_a_valid && a_advance;
    assign o_ready   = !r_a_valid || a_advance;
    assign in_accept = i_valid && o_ready;

    assign cnt_eff = r_a_fwd_hit ? r_a_fwd_data :
                     (r_a_vbit ? ram_rd_data : '0);

    always_comb begin
        logic                bg;
        logic                blank_after;
        logic                open_after;
        logic [COL_W-1:0]    start_after;
        logic [SEG_IDX_W-1:0] seg_addr;

        n_col_num     = r_col_num;
        n_col_blank   = r_col_blank;
        n_run_open    = r_run_open;
        n_run_start   = r_run_start;
        n_merge_act   = r_merge_act;
        n_merge_start = r_merge_start;
        n_seg_count   = r_seg_count;
        wr_en         = 1'b0;
        wr_addr       = SEG_IDX_W'(r_a_mi);
        wr_data       = cnt_eff + CNT_W'(1);
        tbl_clear     = 1'b0;
        emit          = 1'b0;
        emit_first    = r_merge_act ? r_merge_start : r_run_start;
        emit_merged   = r_merge_act;
        seg_addr      = r_seg_count[SEG_IDX_W-1:0];

        if (r_bg_color == '0) begin
            bg = (r_a_pixel[bcs_pkg::CHAN_W-1:0] == '0);
        end else begin
            bg = (r_a_pixel == r_bg_color);
        end
        blank_after = r_col_blank && bg;
        open_after  = r_run_open || !bg;
        start_after = (!bg && !r_run_open) ? r_col_num : r_run_start;

        if (a_fire) begin
            case (r_a_req)
                bcs_pkg::REQ_MERGE: begin
                    if (({24'd0, r_a_mi} < 32'(MAX_SEGMENTS)) && (cnt_eff != '1)) begin
                        wr_en = 1'b1;
                    end
                end
                bcs_pkg::REQ_CLEAR: begin
                    n_col_num     = '0;
                    n_col_blank   = 1'b1;
                    n_run_open    = 1'b0;
                    n_run_start   = '0;
                    n_merge_act   = 1'b0;
                    n_merge_start = '0;
                    n_seg_count   = '0;
                    tbl_clear     = 1'b1;
                end
                bcs_pkg::REQ_PIXEL: begin
                    n_col_blank = blank_after;
                    n_run_open  = open_after;
                    n_run_start = start_after;
                    if (r_a_col_end) begin
                        if (blank_after && open_after) begin
                            n_run_open = 1'b0;
                            if ((r_seg_count < SEG_CNT_W'(MAX_SEGMENTS)) && (cnt_eff != '0)) begin
                                // The run joins the next one: spend one pending merge.
                                wr_en   = 1'b1;
                                wr_addr = seg_addr;
                                wr_data = cnt_eff - CNT_W'(1);
                                if (!r_merge_act) begin
                                    n_merge_act   = 1'b1;
                                    n_merge_start = start_after;
                                end
                            end else begin
                                if (r_seg_count < SEG_CNT_W'(MAX_SEGMENTS)) begin
                                    emit        = 1'b1;
                                    n_seg_count = r_seg_count + SEG_CNT_W'(1);
                                end
                                n_merge_act = 1'b0;
                            end
                        end
                        n_col_blank = 1'b1;
                        if (r_col_num < COL_W'(MAX_COLUMNS - 1)) begin
                            n_col_num = r_col_num + COL_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The incoming request reads the entry for the segment count that the
    // request ahead leaves behind, or its merge index.
    always_comb begin
        if (bcs_pkg::t_req'(i_req_type) == bcs_pkg::REQ_MERGE) begin
            rd_addr = SEG_IDX_W'(i_merge_index);
        end else begin
            rd_addr = n_seg_count[SEG_IDX_W-1:0];
        end
    end

    bcs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_merge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_color    <= '0;
            r_a_valid     <= 1'b0;
            r_col_num     <= '0;
            r_col_blank   <= 1'b1;
            r_run_open    <= 1'b0;
            r_run_start   <= '0;
            r_merge_act   <= 1'b0;
            r_merge_start <= '0;
            r_seg_count   <= '0;
            r_tbl_valid   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_bg_color <= i_cfg_wr_data;
            end
            if (in_accept) begin
                r_a_valid <= 1'b1;
            end else if (a_advance) begin
                r_a_valid <= 1'b0;
            end
            r_col_num     <= n_col_num;
            r_col_blank   <= n_col_blank;
            r_run_open    <= n_run_open;
            r_run_start   <= n_run_start;
            r_merge_act   <= n_merge_act;
            r_merge_start <= n_merge_start;
            r_seg_count   <= n_seg_count;
            if (tbl_clear) begin
                r_tbl_valid <= '0;
            end else if (wr_en) begin
                r_tbl_valid[wr_addr] <= 1'b1;
            end
            if (a_fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_req      <= bcs_pkg::t_req'(i_req_type);
            r_a_pixel    <= {i_red, i_green, i_blue, i_alpha};
            r_a_col_end  <= i_column_end;
            r_a_mi       <= i_merge_index;
            r_a_vbit     <= r_tbl_valid[rd_addr];
            // A clear or a same-entry write in this cycle is not yet in the
            // RAM or the valid bits, so its outcome is carried forward.
            r_a_fwd_hit  <= tbl_clear || (wr_en && (wr_addr == rd_addr));
            r_a_fwd_data <= tbl_clear ? '0 : wr_data;
        end
        if (a_fire && emit) begin
            r_out_seg    <= bcs_pkg::OUT_SEG_W'(r_seg_count);
            r_out_start  <= bcs_pkg::OUT_COL_W'(emit_first);
            r_out_end    <= bcs_pkg::OUT_COL_W'(r_col_num);
            r_out_merged <= emit_merged;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_segment_index = r_out_seg;
    assign o_start_column  = r_out_start;
    assign o_end_column    = r_out_end;
    assign o_was_merged    = r_out_merged;

    // A column with a foreground pixel always has an open run.
    a_blank_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_col_blank |-> r_run_open)
        else $error("non-blank column without an open run");

    // Each emitted segment advances the segment count by exactly one.
    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && emit) |=> (r_seg_count == $past(r_seg_count) + SEG_CNT_W'(1)))
        else $error("segment count did not advance on emission");

    // The segment count never passes its limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_count <= SEG_CNT_W'(MAX_SEGMENTS))
        else $error("segment count beyond limit");

    // A clear request leaves no merge in progress, no open run, no segments counted and an empty table.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && (r_a_req == bcs_pkg::REQ_CLEAR)) |=>
        (!r_merge_act && !r_run_open && (r_seg_count == '0) && (r_tbl_valid == '0)))
        else $error("clear request left state behind");

    // A full stage behind a stalled result must not take another transaction.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_out_valid && !i_ready) |-> !o_ready)
        else $error("request taken while the pipeline is blocked");

endmodule
